// ----- hdl/akvt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the associative key/value table.
package akvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int ENTRY_W = 7;

   typedef enum logic [1:0] {
      ACT_LOOKUP   = 2'd0,
      ACT_SET      = 2'd1,
      ACT_LIST     = 2'd2,
      ACT_RESERVED = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_LISTED    = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_WALK = 2'd1,
      S_DONE = 2'd2
   } fsm_type;

   typedef struct packed {
      action_type           action;
      logic [KEY_W-1:0]     key_tag;
      logic [VALUE_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   result_value;
      logic [ENTRY_W-1:0]   entry_count;
      logic                 last_of_run;
   } rsp_type;

   // Contents of one slot as it moves around the ring.
   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } slot_type;

   // Change applied to the slot word entering a cell.
   typedef struct packed {
      logic                 upd;
      logic                 ins;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } edit_type;

endpackage

// ----- hdl/akvt_cell.sv -----
`timescale 1ns / 1ps
// One slot cell of the rotating ring: takes its neighbor's slot word on each shift.
module akvt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  akvt_pkg::edit_type   edit,
   input  akvt_pkg::slot_type   nbr,
   output akvt_pkg::slot_type   slot
);

   logic                          valid_ff, valid_in;
   logic [akvt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [akvt_pkg::VALUE_W-1:0]  value_ff, value_in;

   always_comb begin
      valid_in = nbr.valid;
      key_in   = nbr.key;
      value_in = nbr.value;
      if (edit.ins) begin
         valid_in = 1'b1;
         key_in   = edit.key;
         value_in = edit.value;
      end else if (edit.upd) begin
         value_in = edit.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.key   = key_ff;
   assign slot.value = value_ff;

endmodule

// ----- hdl/akvt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: walks the ring once per word, edits the head slot and drives results.
module akvt_ctrl #(
   parameter int SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  akvt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output akvt_pkg::rsp_type    rsp_data,
   input  akvt_pkg::slot_type   head,
   output logic                 shift_en,
   output akvt_pkg::edit_type   edit
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   akvt_pkg::fsm_type             state_ff, state_in;
   logic [IDX_W-1:0]              k_ff, k_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   akvt_pkg::req_type             op_ff, op_in;
   logic                          hit_ff, hit_in;
   logic                          done_ff, done_in;
   logic                          ins_ff, ins_in;
   logic [akvt_pkg::VALUE_W-1:0]  hitval_ff, hitval_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   akvt_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          out_free;
   logic                          match;
   logic                          last_k;
   logic                          emit;
   logic                          last_listed;
   akvt_pkg::status_type          fin_status;
   logic [akvt_pkg::VALUE_W-1:0]  fin_value;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign match       = head.valid && (head.key == op_ff.key_tag);
   assign last_k      = (k_ff == IDX_W'(SLOTS - 1));
   assign emit        = (op_ff.action == akvt_pkg::ACT_LIST) && head.valid;
   assign last_listed = ((CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff);

   // Single result of every action but a non-empty list.
   always_comb begin
      fin_status = akvt_pkg::ST_NOT_FOUND;
      fin_value  = '0;
      unique case (op_ff.action)
         akvt_pkg::ACT_LOOKUP: begin
            if (hit_ff) begin
               fin_status = akvt_pkg::ST_FOUND;
               fin_value  = hitval_ff;
            end
         end
         akvt_pkg::ACT_SET: begin
            if (!done_ff) begin
               fin_status = akvt_pkg::ST_FULL;
            end else if (ins_ff) begin
               fin_status = akvt_pkg::ST_INSERTED;
            end else begin
               fin_status = akvt_pkg::ST_UPDATED;
            end
         end
         akvt_pkg::ACT_LIST:     fin_status = akvt_pkg::ST_EMPTY;
         akvt_pkg::ACT_RESERVED: fin_status = akvt_pkg::ST_NOT_FOUND;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      hit_in       = hit_ff;
      done_in      = done_ff;
      ins_in       = ins_ff;
      hitval_in    = hitval_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      req_stall    = 1'b1;
      shift_en     = 1'b0;
      edit         = '0;
      unique case (state_ff)
         akvt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_data;
               k_in     = '0;
               hit_in   = 1'b0;
               done_in  = 1'b0;
               ins_in   = 1'b0;
               state_in = akvt_pkg::S_WALK;
            end
         end
         akvt_pkg::S_WALK: begin
            // hold the ring while a listed word waits for the output register
            if (!emit || out_free) begin
               shift_en = 1'b1;
               k_in     = k_ff + IDX_W'(1);
               unique case (op_ff.action)
                  akvt_pkg::ACT_LOOKUP: begin
                     if (match && !hit_ff) begin
                        hit_in    = 1'b1;
                        hitval_in = head.value;
                     end
                  end
                  akvt_pkg::ACT_SET: begin
                     if (!done_ff) begin
                        if (match) begin
                           edit.upd   = 1'b1;
                           edit.value = op_ff.entry_value;
                           done_in    = 1'b1;
                        end else if (!head.valid) begin
                           edit.ins   = 1'b1;
                           edit.key   = op_ff.key_tag;
                           edit.value = op_ff.entry_value;
                           done_in    = 1'b1;
                           ins_in     = 1'b1;
                           cnt_in     = cnt_ff + CNT_W'(1);
                        end
                     end
                  end
                  akvt_pkg::ACT_LIST: begin
                     if (head.valid) begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.status       = akvt_pkg::ST_LISTED;
                        rsp_in.result_value = head.value;
                        rsp_in.entry_count  = akvt_pkg::ENTRY_W'(cnt_ff);
                        rsp_in.last_of_run  = last_listed;
                     end
                  end
                  akvt_pkg::ACT_RESERVED: ;
               endcase
               if (last_k) begin
                  if ((op_ff.action == akvt_pkg::ACT_LIST) && (cnt_ff != '0)) begin
                     state_in = akvt_pkg::S_IDLE;
                  end else begin
                     state_in = akvt_pkg::S_DONE;
                  end
               end
            end
         end
         akvt_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = fin_status;
               rsp_in.result_value = fin_value;
               rsp_in.entry_count  = akvt_pkg::ENTRY_W'(cnt_ff);
               rsp_in.last_of_run  = 1'b1;
               state_in            = akvt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = akvt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= akvt_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      op_ff     <= op_in;
      hit_ff    <= hit_in;
      done_ff   <= done_in;
      ins_ff    <= ins_in;
      hitval_ff <= hitval_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/assoc_key_value_table_core.sv -----
`timescale 1ns / 1ps
// Top level of the fully associative key/value table.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data): one word per action,
//    lookup, set (update or insert) or list. A word is taken when req_valid is
//    high and req_stall is low; req_stall stays high while an action runs.
//  - Result channel (rsp_valid / rsp_stall / rsp_data): one word per lookup or
//    set, one per valid entry for a list (last_of_run on the final one), and
//    a single empty word for a list of an empty table.
//  - Storage is a ring of SLOTS cells. Each action rotates the ring one full
//    turn, one slot per cycle unless a list freezes it, and works on the
//    head slot, so no wide compare or priority search across all slots is needed.
//  - Timing: a lookup, set or empty list walks the ring once in state WALK, then
//    loads its result into the output register in state DONE and returns to
//    IDLE for the next request; the rotation length sets the pace. A list
//    emits its words during the rotation, one per valid slot, and frees the
//    request side at the end of the rotation, later if the ring was frozen.
//  - Receiver stall: the output register holds its word; a list freezes the
//    ring until the pending word is taken, other actions wait at the end.
//  - Reset clears every valid mark and the entry count.
module assoc_key_value_table_core #(
   parameter int SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  akvt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output akvt_pkg::rsp_type    rsp_data
);

   akvt_pkg::slot_type  slot_q [SLOTS];
   akvt_pkg::edit_type  edit_q [SLOTS];
   akvt_pkg::edit_type  tail_edit;
   logic                shift_en;

   // Sequencer: sees the head cell, edits the word wrapping to the tail.
   akvt_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .head      (slot_q[0]),
      .shift_en  (shift_en),
      .edit      (tail_edit)
   );

   // Ring of cells: cell i takes cell i+1, the tail takes the edited head.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      localparam int NBR = (i == SLOTS - 1) ? 0 : i + 1;

      if (i == SLOTS - 1) begin : g_tail
         assign edit_q[i] = tail_edit;
      end else begin : g_body
         assign edit_q[i] = '0;
      end

      akvt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .edit     (edit_q[i]),
         .nbr      (slot_q[NBR]),
         .slot     (slot_q[i])
      );
   end

endmodule
